// ===== sv/kmsb_pkg.sv =====
// Shared types, constants and the hash step function for the k-mer set block.
package kmsb_pkg;

    localparam int KEY_W = 64;
    localparam int MAX_K = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam logic [5:0] KMER_LEN_RESET = 6'd31;
    localparam logic [2:0] MIX_LAST_STEP = 3'd6;
    localparam logic REG_KMER_LEN = 1'b0;

    typedef struct packed {
        logic       command;
        logic [7:0] base_char;
        logic       is_last;
    } item_t;

    typedef struct packed {
        logic read_hit;
        logic table_full;
    } result_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_INSERT,
        OP_LOOKUP
    } op_t;

    typedef struct packed {
        op_t              op;
        logic             last;
        logic [KEY_W-1:0] fwd;
        logic [KEY_W-1:0] rev;
    } job_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_MOD,
        ST_READ,
        ST_CHECK,
        ST_OUT
    } bk_state_t;

    // One step of the 64-bit integer mixing hash.
    function automatic logic [KEY_W-1:0] mix_step(input logic [KEY_W-1:0] v,
                                                  input logic [2:0] idx);
        logic [KEY_W-1:0] r;
        begin
            case (idx)
                3'd0: r = ~v + (v << 21);
                3'd1: r = v ^ (v >> 24);
                3'd2: r = v + (v << 3) + (v << 8);
                3'd3: r = v ^ (v >> 14);
                3'd4: r = v + (v << 2) + (v << 4);
                3'd5: r = v ^ (v >> 28);
                3'd6: r = v + (v << 31);
                default: r = v;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== sv/kmsb_front.sv =====
// Front part: decodes characters, keeps both k-mer windows and classifies each beat.
module kmsb_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  kmsb_pkg::item_t     item,
    input  logic [5:0]          kmer_len,
    input  logic                q_ready,
    output logic                push,
    output kmsb_pkg::job_t      job
);

    logic [63:0] fwd_reg, fwd_next, rev_reg, rev_next;
    logic [5:0]  run_reg, run_next;
    logic [5:0]  k;
    logic [63:0] mask;
    logic [6:0]  shift;
    logic [2:0]  code;
    logic [63:0] fwd_new, rev_new;
    logic [5:0]  run_new;
    logic        complete;
    logic        accept;
    kmsb_pkg::op_t op;

    assign item_stall = !q_ready;
    assign accept = item_valid && !item_stall;

    always_comb
    begin
        case (item.base_char)
            8'h41, 8'h61: code = 3'd0;
            8'h43, 8'h63: code = 3'd1;
            8'h47, 8'h67: code = 3'd2;
            8'h54, 8'h74: code = 3'd3;
            default:      code = 3'd4;
        endcase
    end

    always_comb
    begin
        if (kmer_len == 6'd0)
            k = 6'd1;
        else if (kmer_len > 6'(kmsb_pkg::MAX_K))
            k = 6'(kmsb_pkg::MAX_K);
        else
            k = kmer_len;
        mask  = (k == 6'(kmsb_pkg::MAX_K)) ? '1 : ((64'd1 << {k, 1'b0}) - 64'd1);
        shift = {k - 6'd1, 1'b0};
        if (code[2])
        begin
            fwd_new  = '0;
            rev_new  = '0;
            run_new  = '0;
            complete = 1'b0;
        end
        else
        begin
            fwd_new  = ((fwd_reg << 2) | {62'd0, code[1:0]}) & mask;
            rev_new  = ((rev_reg >> 2) | ({62'd0, 2'd3 - code[1:0]} << shift)) & mask;
            run_new  = (run_reg < 6'(kmsb_pkg::MAX_K)) ? run_reg + 6'd1 : run_reg;
            complete = run_new >= k;
        end
        if (!complete)
            op = kmsb_pkg::OP_NONE;
        else if (item.command)
            op = kmsb_pkg::OP_LOOKUP;
        else
            op = kmsb_pkg::OP_INSERT;
    end

    always_comb
    begin
        fwd_next = fwd_reg;
        rev_next = rev_reg;
        run_next = run_reg;
        if (accept)
        begin
            fwd_next = item.is_last ? '0 : fwd_new;
            rev_next = item.is_last ? '0 : rev_new;
            run_next = item.is_last ? '0 : run_new;
        end
    end

    assign push = accept && (op != kmsb_pkg::OP_NONE || item.is_last);
    assign job  = '{op: op, last: item.is_last, fwd: fwd_new, rev: rev_new};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= '0;
            rev_reg <= '0;
            run_reg <= '0;
        end
        else
        begin
            fwd_reg <= fwd_next;
            rev_reg <= rev_next;
            run_reg <= run_next;
        end
    end

endmodule

// ===== sv/kmsb_queue.sv =====
// Short job queue between the front and back parts.
module kmsb_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  kmsb_pkg::job_t push_job,
    input  logic           pop,
    output kmsb_pkg::job_t head_job,
    output logic           empty,
    output logic           full
);

    kmsb_pkg::job_t entry_reg [kmsb_pkg::QUEUE_DEPTH];
    logic [kmsb_pkg::QUEUE_PTR_W-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [kmsb_pkg::QUEUE_PTR_W:0]   cnt_reg, cnt_next;

    assign empty    = cnt_reg == '0;
    assign full     = cnt_reg == (kmsb_pkg::QUEUE_PTR_W + 1)'(kmsb_pkg::QUEUE_DEPTH);
    assign head_job = entry_reg[rd_reg];

    always_comb
    begin
        wr_next  = (push && !full) ? wr_reg + 1'b1 : wr_reg;
        rd_next  = (pop && !empty) ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg;
        if (push && !full && !(pop && !empty))
            cnt_next = cnt_reg + 1'b1;
        else if (!(push && !full) && pop && !empty)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
            entry_reg[wr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== sv/kmsb_back.sv =====
// Back part: hashes keys, probes the open-addressed table and builds results.
module kmsb_back #(
    parameter int TABLE_ENTRIES = 65536
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  kmsb_pkg::job_t     q_job,
    output logic               q_pop,
    output logic               clearing,
    output logic               result_valid,
    input  logic               result_stall,
    output kmsb_pkg::result_t  result
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam bit IS_POW2 = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;
    localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_ENTRIES - 1);
    localparam logic [63:0] M64 = 64'(TABLE_ENTRIES);
    localparam logic [31:0] FOLD_R = 32'((64'd1 << 32) % 64'(TABLE_ENTRIES));
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(TABLE_ENTRIES));
    localparam logic [5:0] PH_RECIP = 6'd0;
    localparam logic [5:0] PH_SCALE = 6'd1;
    localparam logic [5:0] PH_TRIM = 6'd2;

    logic [kmsb_pkg::KEY_W:0] mem [TABLE_ENTRIES];
    logic [kmsb_pkg::KEY_W:0] rd_data_reg;

    kmsb_pkg::bk_state_t state_reg, state_next;
    kmsb_pkg::job_t      job_reg, job_next;
    logic                second_reg, second_next;
    logic [63:0]         v_reg, v_next;
    logic [31:0]         q_reg, q_next;
    logic [2:0]          step_reg, step_next;
    logic [5:0]          bit_reg, bit_next;
    logic [AW-1:0]       addr_reg, addr_next, count_reg, count_next;
    logic                hit_reg, hit_next, drop_reg, drop_next;
    logic                res_valid_reg, res_valid_next;
    kmsb_pkg::result_t   res_reg, res_next;

    logic [63:0]         key;
    logic [63:0]         mixed;
    logic [63:0]         fold_sum, recip_prod, q_mul;
    logic                mod_done;
    logic [AW-1:0]       addr_inc;
    logic                used, match, exhausted, done;
    logic                wr_en, load_result;
    logic [AW-1:0]       wr_addr;
    logic [kmsb_pkg::KEY_W:0] wr_data;

    assign key        = second_reg ? job_reg.rev : job_reg.fwd;
    assign mixed      = kmsb_pkg::mix_step(v_reg, step_reg);
    assign fold_sum   = ({32'd0, v_reg[63:32]} * {32'd0, FOLD_R}) + {32'd0, v_reg[31:0]};
    assign recip_prod = {32'd0, v_reg[31:0]} * {32'd0, RECIP};
    assign q_mul      = {32'd0, q_reg} * M64;
    assign mod_done   = bit_reg == PH_TRIM && v_reg < M64;
    assign addr_inc   = (addr_reg == LAST_SLOT) ? '0 : addr_reg + 1'b1;
    assign used       = rd_data_reg[kmsb_pkg::KEY_W];
    assign match      = rd_data_reg[kmsb_pkg::KEY_W-1:0] == key;
    assign exhausted  = count_reg == LAST_SLOT;
    assign done       = !used || match || exhausted;
    assign clearing   = state_reg == kmsb_pkg::ST_CLEAR;

    always_comb
    begin
        q_pop       = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = addr_reg;
        wr_data     = '0;
        load_result = 1'b0;
        case (state_reg)
            kmsb_pkg::ST_CLEAR: wr_en = 1'b1;
            kmsb_pkg::ST_IDLE:  q_pop = !q_empty;
            kmsb_pkg::ST_CHECK:
            begin
                wr_en   = job_reg.op == kmsb_pkg::OP_INSERT && !used;
                wr_data = {1'b1, key};
            end
            kmsb_pkg::ST_OUT:   load_result = !res_valid_reg || !result_stall;
            default: ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            kmsb_pkg::ST_CLEAR:
                if (addr_reg == LAST_SLOT)
                    state_next = kmsb_pkg::ST_IDLE;
            kmsb_pkg::ST_IDLE:
                if (!q_empty)
                    state_next = (q_job.op == kmsb_pkg::OP_NONE) ? kmsb_pkg::ST_OUT
                                                                : kmsb_pkg::ST_HASH;
            kmsb_pkg::ST_HASH:
                if (step_reg == kmsb_pkg::MIX_LAST_STEP)
                    state_next = IS_POW2 ? kmsb_pkg::ST_READ : kmsb_pkg::ST_MOD;
            kmsb_pkg::ST_MOD:
                if (mod_done)
                    state_next = kmsb_pkg::ST_READ;
            kmsb_pkg::ST_READ:
                state_next = kmsb_pkg::ST_CHECK;
            kmsb_pkg::ST_CHECK:
                if (!done)
                    state_next = kmsb_pkg::ST_READ;
                else if (job_reg.op == kmsb_pkg::OP_INSERT && !second_reg)
                    state_next = kmsb_pkg::ST_HASH;
                else if (job_reg.last)
                    state_next = kmsb_pkg::ST_OUT;
                else
                    state_next = kmsb_pkg::ST_IDLE;
            kmsb_pkg::ST_OUT:
                if (load_result)
                    state_next = kmsb_pkg::ST_IDLE;
            default:
                state_next = kmsb_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        job_next       = job_reg;
        second_next    = second_reg;
        v_next         = v_reg;
        q_next         = q_reg;
        step_next      = step_reg;
        bit_next       = bit_reg;
        addr_next      = addr_reg;
        count_next     = count_reg;
        hit_next       = hit_reg;
        drop_next      = drop_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && result_stall;
        case (state_reg)
            kmsb_pkg::ST_CLEAR:
                addr_next = addr_inc;
            kmsb_pkg::ST_IDLE:
                if (!q_empty)
                begin
                    job_next    = q_job;
                    second_next = 1'b0;
                    v_next      = q_job.fwd;
                    step_next   = '0;
                end
            kmsb_pkg::ST_HASH:
            begin
                v_next     = mixed;
                step_next  = step_reg + 3'd1;
                count_next = '0;
                bit_next   = PH_RECIP;
                addr_next  = IS_POW2 ? mixed[AW-1:0] : '0;
            end
            kmsb_pkg::ST_MOD:
            begin
                // Fold the upper half down until the value fits in 32 bits, then
                // estimate the quotient by reciprocal and trim the remainder.
                if (v_reg[63:32] != '0)
                    v_next = fold_sum;
                else if (bit_reg == PH_RECIP)
                begin
                    q_next   = recip_prod[63:32];
                    bit_next = PH_SCALE;
                end
                else if (bit_reg == PH_SCALE)
                begin
                    v_next   = v_reg - q_mul;
                    bit_next = PH_TRIM;
                end
                else if (v_reg >= M64)
                    v_next = v_reg - M64;
                else
                    addr_next = v_reg[AW-1:0];
            end
            kmsb_pkg::ST_CHECK:
            begin
                if (!done)
                begin
                    addr_next  = addr_inc;
                    count_next = count_reg + 1'b1;
                end
                else if (job_reg.op == kmsb_pkg::OP_INSERT && !second_reg)
                begin
                    second_next = 1'b1;
                    v_next      = job_reg.rev;
                    step_next   = '0;
                end
                if (job_reg.op == kmsb_pkg::OP_INSERT && used && !match && exhausted)
                    drop_next = 1'b1;
                if (job_reg.op == kmsb_pkg::OP_LOOKUP && used && match)
                    hit_next = 1'b1;
            end
            kmsb_pkg::ST_OUT:
                if (load_result)
                begin
                    res_valid_next = 1'b1;
                    res_next       = '{read_hit: hit_reg, table_full: drop_reg};
                    hit_next       = 1'b0;
                    drop_next      = 1'b0;
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[addr_reg];
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        v_reg   <= v_next;
        q_reg   <= q_next;
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kmsb_pkg::ST_CLEAR;
            second_reg    <= 1'b0;
            step_reg      <= '0;
            bit_reg       <= '0;
            addr_reg      <= '0;
            count_reg     <= '0;
            hit_reg       <= 1'b0;
            drop_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            second_reg    <= second_next;
            step_reg      <= step_next;
            bit_reg       <= bit_next;
            addr_reg      <= addr_next;
            count_reg     <= count_next;
            hit_reg       <= hit_next;
            drop_reg      <= drop_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == kmsb_pkg::ST_CLEAR |-> !q_pop)
        else $error("job taken during table clear");

    a_check_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == kmsb_pkg::ST_CHECK |-> $past(state_reg) == kmsb_pkg::ST_READ)
        else $error("probe compare without a preceding read");

    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg) == kmsb_pkg::ST_OUT)
        else $error("result raised outside the output state");

endmodule

// ===== sv/kmer_set_build_and_match.sv =====
// Top level of the k-mer set builder and matcher.
// Input beats carry one sequence character with an insert or lookup command and a
// last-character mark. Insert beats add every complete forward and reverse-complement
// k-mer to a hash set; lookup beats test forward k-mers against it. A result beat,
// with the hit and table-full flags, follows only the last character of a sequence.
// The front part updates the windows in the cycle a beat is accepted and queues a job
// for the back part through a four-entry queue. The back part hashes each key with
// the mixing hash (then folds and reduces it by reciprocal when the table size is
// not a power of two) and probes the table slot by slot, reading then comparing each.
// An insert hashes and probes both its keys and a lookup its forward key only; a last
// beat then passes through the output state for the result, and a beat that completes
// no k-mer and is not last queues no job for the back part.
// After reset the back part clears the table, one entry a cycle; input stall stays
// high meanwhile. kmer_len resets to 31. Result beats sit in an output register;
// when the receiver stalls, the back part waits but the front keeps accepting beats
// until the queue fills.
module kmer_set_build_and_match #(
    parameter int TABLE_ENTRIES = 65536
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  kmsb_pkg::item_t    item,
    output logic               result_valid,
    input  logic               result_stall,
    output kmsb_pkg::result_t  result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [5:0]     kmer_len_reg, kmer_len_next;
    logic           push, pop, q_empty, q_full, clearing;
    kmsb_pkg::job_t push_job, head_job;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == kmsb_pkg::REG_KMER_LEN) ? {26'd0, kmer_len_reg} : '0;

    always_comb
    begin
        kmer_len_next = kmer_len_reg;
        if (psel && penable && pwrite && pready && paddr[2] == kmsb_pkg::REG_KMER_LEN)
            kmer_len_next = pwdata[5:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            kmer_len_reg <= kmsb_pkg::KMER_LEN_RESET;
        else
            kmer_len_reg <= kmer_len_next;
    end

    kmsb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .kmer_len   (kmer_len_reg),
        .q_ready    (!q_full && !clearing),
        .push       (push),
        .job        (push_job)
    );

    kmsb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .empty    (q_empty),
        .full     (q_full)
    );

    kmsb_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_job        (head_job),
        .q_pop        (pop),
        .clearing     (clearing),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the k-mer set builder and matcher.
module testbench;

    localparam int TBL = 65536;
    localparam int CYCLE_LIMIT = 3000000;
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_stall;
    kmsb_pkg::item_t item = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    kmsb_pkg::result_t result;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    kmer_set_build_and_match #(.TABLE_ENTRIES(TBL)) u_top (.*);

    always #1 clk = ~clk;

    // Predictor state.
    logic [63:0] keys [TBL];
    bit used [TBL];
    logic [63:0] fwd_win, rev_win;
    int run_len;
    bit hit_flag, drop_flag;
    logic [5:0] klen_reg = 6'd31;
    kmsb_pkg::result_t flags_due [$];
    int errors = 0;
    longint cycles = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    bit hold_off = 1'b0;

    function automatic logic [63:0] mix64(logic [63:0] v);
        v = ~v + (v << 21);
        v = v ^ (v >> 24);
        v = v + (v << 3) + (v << 8);
        v = v ^ (v >> 14);
        v = v + (v << 2) + (v << 4);
        v = v ^ (v >> 28);
        v = v + (v << 31);
        return v;
    endfunction

    function automatic void set_add(logic [63:0] key);
        int pos;
        pos = int'(mix64(key) % TBL);
        for (int n = 0; n < TBL; n++)
        begin
            if (!used[pos])
            begin
                used[pos] = 1'b1;
                keys[pos] = key;
                return;
            end
            if (keys[pos] == key)
                return;
            pos = (pos + 1) % TBL;
        end
        drop_flag = 1'b1;
    endfunction

    function automatic bit set_has(logic [63:0] key);
        int pos;
        pos = int'(mix64(key) % TBL);
        for (int n = 0; n < TBL; n++)
        begin
            if (!used[pos])
                return 1'b0;
            if (keys[pos] == key)
                return 1'b1;
            pos = (pos + 1) % TBL;
        end
        return 1'b0;
    endfunction

    function automatic void predict_char(kmsb_pkg::item_t it);
        int k;
        int c;
        logic [63:0] mask;
        kmsb_pkg::result_t r;
        k = klen_reg;
        if (k < 1) k = 1;
        if (k > 32) k = 32;
        mask = (k == 32) ? '1 : ((64'd1 << (2 * k)) - 64'd1);
        case (it.base_char)
            "A", "a": c = 0;
            "C", "c": c = 1;
            "G", "g": c = 2;
            "T", "t": c = 3;
            default: c = 4;
        endcase
        if (c < 4)
        begin
            fwd_win = ((fwd_win << 2) | 64'(c)) & mask;
            rev_win = ((rev_win >> 2) | (64'(3 - c) << (2 * (k - 1)))) & mask;
            if (run_len < 32) run_len++;
            if (run_len >= k)
            begin
                if (it.command == CMD_INSERT)
                begin
                    set_add(fwd_win);
                    set_add(rev_win);
                end
                else if (set_has(fwd_win))
                    hit_flag = 1'b1;
            end
        end
        else
        begin
            fwd_win = '0;
            rev_win = '0;
            run_len = 0;
        end
        if (it.is_last)
        begin
            r.read_hit = hit_flag;
            r.table_full = drop_flag;
            flags_due.push_back(r);
            fwd_win = '0;
            rev_win = '0;
            run_len = 0;
            hit_flag = 1'b0;
            drop_flag = 1'b0;
        end
    endfunction

    // Offers one beat from the next falling edge and returns at the accepting edge.
    task automatic send_char(logic cmd, logic [7:0] ch, logic last);
        kmsb_pkg::item_t it;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        it.command = cmd;
        it.base_char = ch;
        it.is_last = last;
        item_valid <= 1'b1;
        item <= it;
        do @(posedge clk); while (item_stall);
        predict_char(it);
    endtask

    task automatic stop_input();
        @(negedge clk);
        item_valid <= 1'b0;
    endtask

    task automatic send_seq(logic cmd, string s, bit mixed);
        for (int i = 0; i < s.len(); i++)
            send_char(mixed ? logic'($urandom_range(1)) : cmd, s[i], i == s.len() - 1);
    endtask

    function automatic string random_dna(int n, int n_pct);
        string s;
        string acgt;
        s = "";
        acgt = "ACGTacgt";
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < n_pct)
                s = {s, string'(byte'($urandom_range(255, 1)))};
            else
                s = {s, string'(acgt[$urandom_range(7)])};
        end
        return s;
    endfunction

    task automatic wait_drained();
        stop_input();
        while (flags_due.size() != 0)
            @(negedge clk);
        repeat (400) @(negedge clk);
    endtask

    task automatic write_kmer_len(logic [5:0] v);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 3'(4 * kmsb_pkg::REG_KMER_LEN);
        pwdata <= 32'(v);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        klen_reg = v;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        kmsb_pkg::result_t exp_r;
        cycles++;
        if (result_valid && !result_stall)
        begin
            if (flags_due.size() == 0)
            begin
                $error("result beat with nothing expected");
                errors++;
            end
            else
            begin
                exp_r = flags_due.pop_front();
                if (result.read_hit !== exp_r.read_hit)
                begin
                    $error("read_hit expected %0b actual %0b", exp_r.read_hit, result.read_hit);
                    errors++;
                end
                if (result.table_full !== exp_r.table_full)
                begin
                    $error("table_full expected %0b actual %0b", exp_r.table_full,
                           result.table_full);
                    errors++;
                end
            end
        end
        if (cycles > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(negedge clk)
        result_stall <= hold_off || ($urandom_range(99) < stall_pct);

    task automatic test_directed();
        send_seq(CMD_INSERT, "ACGTACGTAC", 1'b0);
        send_seq(CMD_LOOKUP, "ACGTACGTAC", 1'b0);
        wait_drained();
        write_kmer_len(6'd1);
        send_seq(CMD_INSERT, "A", 1'b0);
        send_seq(CMD_LOOKUP, "TaXg", 1'b0);
        wait_drained();
        write_kmer_len(6'd32);
        send_seq(CMD_INSERT, "ACGTTGCAACGTTGCAACGTTGCAACGTTGCAGG", 1'b0);
        send_seq(CMD_LOOKUP, "ACGTTGCAACGTTGCAACGTTGCAACGTTGCAGG", 1'b0);
        wait_drained();
        write_kmer_len(6'd0);
        send_seq(CMD_LOOKUP, {"C", 8'hff, 8'h01, "t"}, 1'b0);
        wait_drained();
        write_kmer_len(6'd63);
        send_seq(CMD_LOOKUP, "GATTACA", 1'b1);
        wait_drained();
    endtask

    task automatic test_random(int n_seq);
        logic [5:0] lens [6] = '{6'd3, 6'd5, 6'd8, 6'd11, 6'd31, 6'd32};
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 73;
                    stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct = 73;
                end
                default:
                begin
                    send_idle_pct = 18;
                    stall_pct = 18;
                end
            endcase
            write_kmer_len(lens[$urandom_range(5)]);
            for (int s = 0; s < n_seq; s++)
                send_seq(logic'($urandom_range(1)), random_dna($urandom_range(1, 12), 8),
                         $urandom_range(3) == 0);
            wait_drained();
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct = 0;
        write_kmer_len(6'd2);
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(negedge clk);
                hold_off = 1'b0;
            end
            begin
                for (int s = 0; s < 12; s++)
                    send_seq(logic'(s % 2), random_dna(3, 0), 1'b0);
                stop_input();
            end
        join
        wait_drained();
    endtask

    initial
    begin
        fwd_win = '0;
        rev_win = '0;
        run_len = 0;
        hit_flag = 1'b0;
        drop_flag = 1'b0;
        foreach (used[i]) used[i] = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random(10);
        test_backpressure();
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

// ===== sim.f =====
sv/kmsb_pkg.sv
sv/kmsb_front.sv
sv/kmsb_queue.sv
sv/kmsb_back.sv
sv/kmer_set_build_and_match.sv
dv/testbench.sv
